// ===== rtl/rbnr_pkg.sv =====
package rbnr_pkg;

   localparam int HIST_BINS_DEF = 128;
   localparam int LQ_SLOTS_DEF  = 50;
   localparam int FIFO_DEPTH    = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   typedef enum logic [1:0] {
      KIND_PACKET = 2'd0,
      KIND_EMPTY  = 2'd1,
      KIND_BG     = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GUARD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NEAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR    = 3'd4;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [7:0]  rssi_dbm;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  report_rssi;
      logic [6:0]         lq_percent;
      logic [7:0]         near_count;
      logic [7:0]         far_count;
      logic signed [7:0]  far_max;
      logic signed [7:0]  background_dbm;
      logic               background_valid;
   } rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [7:0]  rssi_dbm;
      logic [31:0]        now_ms;
   } cmd_type;

   typedef struct packed {
      logic [6:0]         guard_db;
      logic [15:0]        min_bg_packets;
      logic [7:0]         min_near_packets;
      logic [15:0]        hold_time_ms;
      logic signed [7:0]  floor_dbm;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PKT_RD,
      ST_PKT_WR,
      ST_BG_RD,
      ST_BG_WALK,
      ST_CLEAR,
      ST_REPORT
   } state_type;

endpackage

// ===== rtl/rbnr_front.sv =====
module rbnr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rbnr_pkg::req_type    req_data,
   output logic                 cmd_valid,
   input  logic                 cmd_pop,
   output rbnr_pkg::cmd_type    cmd_data
);

   localparam int PtrW = $clog2(rbnr_pkg::FIFO_DEPTH);

   rbnr_pkg::cmd_type     fifo_ff [rbnr_pkg::FIFO_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]         count_ff, count_in;
   logic                  push;
   rbnr_pkg::cmd_type     cmd_new;

   assign req_stall = (count_ff == (PtrW+1)'(rbnr_pkg::FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = fifo_ff[rd_ptr_ff];

   // classify by kind; unused fields dropped
   always_comb begin
      cmd_new.kind     = rbnr_pkg::kind_type'(req_data.kind);
      cmd_new.rssi_dbm = (req_data.kind == rbnr_pkg::KIND_PACKET) ? req_data.rssi_dbm : '0;
      cmd_new.now_ms   = (req_data.kind == rbnr_pkg::KIND_REPORT) ? req_data.now_ms : '0;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (cmd_pop && cmd_valid) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== rtl/rbnr_back.sv =====
module rbnr_back #(
   parameter int HIST_BINS = rbnr_pkg::HIST_BINS_DEF,
   parameter int LQ_SLOTS  = rbnr_pkg::LQ_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rbnr_pkg::cfg_type    cfg,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   input  rbnr_pkg::cmd_type    cmd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rbnr_pkg::rsp_type    rsp_data
);

   localparam int BinW  = $clog2(HIST_BINS);
   localparam int SlotW = (LQ_SLOTS > 1) ? $clog2(LQ_SLOTS) : 1;
   localparam int TotW  = $clog2(LQ_SLOTS + 1);

   logic [15:0]           hist_mem [HIST_BINS];
   logic [15:0]           hist_rd_ff;
   logic [HIST_BINS-1:0]  hvalid_ff, hvalid_in;
   logic                  hwe;
   logic [BinW-1:0]       hwaddr, hraddr;
   logic [15:0]           hwdata;

   rbnr_pkg::state_type   state_ff, state_in;
   rbnr_pkg::cmd_type     cur_ff, cur_in;
   logic [BinW-1:0]       idx_ff, idx_in;
   logic [BinW:0]         walk_ff, walk_in;
   logic [16:0]           total_ff, total_in;
   logic [15:0]           best_ff, best_in;
   logic [BinW-1:0]       best_idx_ff, best_idx_in;
   logic                  found_ff, found_in;

   logic signed [7:0]     bg_level_ff, bg_level_in;
   logic                  bg_valid_ff, bg_valid_in;
   logic signed [7:0]     near_peak_ff, near_peak_in;
   logic [7:0]            near_tally_ff, near_tally_in;
   logic signed [7:0]     far_peak_ff, far_peak_in;
   logic [7:0]            far_tally_ff, far_tally_in;
   logic signed [7:0]     held_ff, held_in;
   logic [31:0]           last_ff, last_in;
   logic                  seen_ff, seen_in;
   logic [LQ_SLOTS-1:0]   slots_ff, slots_in;
   logic [SlotW-1:0]      lq_ptr_ff, lq_ptr_in;
   logic [TotW-1:0]       lq_total_ff, lq_total_in;

   logic                  out_valid_ff, out_valid_in;
   rbnr_pkg::rsp_type     out_ff, out_in;

   logic [15:0]           bin_val;
   logic signed [9:0]     r_ext, hi_th, lo_th;
   logic [6:0]            pct_full;
   logic [31:0]           dt;

   assign bin_val = hvalid_ff[idx_ff] ? hist_rd_ff : 16'd0;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (hwe) begin
         hist_mem[hwaddr] <= hwdata;
      end
      hist_rd_ff <= hist_mem[hraddr];
   end

   always_comb begin
      r_ext    = 10'(cur_ff.rssi_dbm);
      hi_th    = 10'(bg_level_ff) + 10'(cfg.guard_db);
      lo_th    = 10'(bg_level_ff) - 10'(cfg.guard_db);
      // percent lookup over every possible window total
      pct_full = '0;
      for (int t = 0; t <= LQ_SLOTS; t++) begin
         if (lq_total_ff == TotW'(t)) pct_full = 7'((t * 100) / LQ_SLOTS);
      end
      dt       = cmd_data.now_ms - last_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      walk_in       = walk_ff;
      total_in      = total_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      bg_level_in   = bg_level_ff;
      bg_valid_in   = bg_valid_ff;
      near_peak_in  = near_peak_ff;
      near_tally_in = near_tally_ff;
      far_peak_in   = far_peak_ff;
      far_tally_in  = far_tally_ff;
      held_in       = held_ff;
      last_in       = last_ff;
      seen_in       = seen_ff;
      slots_in      = slots_ff;
      lq_ptr_in     = lq_ptr_ff;
      lq_total_in   = lq_total_ff;
      hvalid_in     = hvalid_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      cmd_pop       = 1'b0;
      hwe           = 1'b0;
      hwaddr        = idx_ff;
      hwdata        = '0;
      hraddr        = idx_ff;

      unique case (state_ff)
         rbnr_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd_data;
               unique case (cmd_data.kind)
                  rbnr_pkg::KIND_PACKET: begin
                     cmd_pop = 1'b1;
                     if (cmd_data.rssi_dbm > 0) begin
                        idx_in = '0;
                     end else if (-10'(cmd_data.rssi_dbm) > 10'(HIST_BINS - 1)) begin
                        idx_in = BinW'(HIST_BINS - 1);
                     end else begin
                        idx_in = BinW'(-10'(cmd_data.rssi_dbm));
                     end
                     state_in = rbnr_pkg::ST_PKT_RD;
                  end
                  rbnr_pkg::KIND_EMPTY: begin
                     cmd_pop = 1'b1;
                     if (slots_ff[lq_ptr_ff] && lq_total_ff != '0) begin
                        lq_total_in = lq_total_ff - 1'b1;
                     end
                     slots_in[lq_ptr_ff] = 1'b0;
                     lq_ptr_in = (lq_ptr_ff == SlotW'(LQ_SLOTS - 1)) ? '0 : lq_ptr_ff + 1'b1;
                  end
                  rbnr_pkg::KIND_BG: begin
                     cmd_pop     = 1'b1;
                     idx_in      = '0;
                     hraddr      = '0;
                     walk_in     = '0;
                     total_in    = '0;
                     best_in     = '0;
                     best_idx_in = '0;
                     found_in    = 1'b0;
                     state_in    = rbnr_pkg::ST_BG_RD;
                  end
                  rbnr_pkg::KIND_REPORT: begin
                     // hold until the output register is free
                     if (!out_valid_ff || !rsp_stall) begin
                        cmd_pop = 1'b1;
                        out_valid_in = 1'b1;
                        if (bg_valid_ff && near_tally_ff >= cfg.min_near_packets) begin
                           held_in = near_peak_ff;
                           last_in = cmd_data.now_ms;
                           seen_in = 1'b1;
                           out_in.report_rssi = near_peak_ff;
                        end else if (seen_ff && dt < 32'(cfg.hold_time_ms)) begin
                           out_in.report_rssi = held_ff;
                        end else begin
                           out_in.report_rssi = cfg.floor_dbm;
                           held_in = cfg.floor_dbm;
                        end
                        out_in.lq_percent       = pct_full;
                        out_in.near_count       = near_tally_ff;
                        out_in.far_count        = far_tally_ff;
                        out_in.far_max          = far_peak_ff;
                        out_in.background_dbm   = bg_level_ff;
                        out_in.background_valid = bg_valid_ff;
                        near_peak_in  = cfg.floor_dbm;
                        near_tally_in = '0;
                        far_peak_in   = cfg.floor_dbm;
                        far_tally_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         rbnr_pkg::ST_PKT_RD: begin
            state_in = rbnr_pkg::ST_PKT_WR;
         end
         rbnr_pkg::ST_PKT_WR: begin
            hwe      = 1'b1;
            hwdata   = (bin_val == 16'hFFFF) ? bin_val : bin_val + 16'd1;
            hvalid_in[idx_ff] = 1'b1;
            if (slots_ff[lq_ptr_ff] && lq_total_ff != '0) begin
               lq_total_in = lq_total_ff;
            end else begin
               lq_total_in = lq_total_ff + 1'b1;
            end
            slots_in[lq_ptr_ff] = 1'b1;
            lq_ptr_in = (lq_ptr_ff == SlotW'(LQ_SLOTS - 1)) ? '0 : lq_ptr_ff + 1'b1;
            if (bg_valid_ff) begin
               if (r_ext > hi_th) begin
                  if (cur_ff.rssi_dbm > near_peak_ff) near_peak_in = cur_ff.rssi_dbm;
                  if (near_tally_ff != 8'hFF) near_tally_in = near_tally_ff + 8'd1;
               end else if (r_ext < lo_th) begin
                  if (cur_ff.rssi_dbm > far_peak_ff) far_peak_in = cur_ff.rssi_dbm;
                  if (far_tally_ff != 8'hFF) far_tally_in = far_tally_ff + 8'd1;
               end
            end
            state_in = rbnr_pkg::ST_IDLE;
         end
         rbnr_pkg::ST_BG_RD: begin
            state_in = rbnr_pkg::ST_BG_WALK;
         end
         rbnr_pkg::ST_BG_WALK: begin
            // one bin per pass: read in ST_BG_RD, then accumulate here
            total_in = (total_ff + 17'(bin_val) > 17'hFFFF) ? 17'hFFFF
                                                           : total_ff + 17'(bin_val);
            if (bin_val > best_ff) begin
               best_in     = bin_val;
               best_idx_in = idx_ff;
               found_in    = 1'b1;
            end
            if (walk_ff == (BinW+1)'(HIST_BINS - 1)) begin
               state_in = rbnr_pkg::ST_CLEAR;
            end else begin
               walk_in  = walk_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               hraddr   = idx_ff + 1'b1;
               state_in = rbnr_pkg::ST_BG_RD;
            end
         end
         rbnr_pkg::ST_CLEAR: begin
            bg_valid_in = (total_ff >= 17'(cfg.min_bg_packets)) && found_ff;
            if ((total_ff >= 17'(cfg.min_bg_packets)) && found_ff) begin
               bg_level_in = -8'(best_idx_ff);
            end
            hvalid_in = '0;
            state_in  = rbnr_pkg::ST_IDLE;
         end
         default: state_in = rbnr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rbnr_pkg::ST_IDLE;
         hvalid_ff     <= '0;
         bg_level_ff   <= -8'sd128;
         bg_valid_ff   <= 1'b0;
         near_peak_ff  <= -8'sd128;
         near_tally_ff <= '0;
         far_peak_ff   <= -8'sd128;
         far_tally_ff  <= '0;
         held_ff       <= -8'sd128;
         last_ff       <= '0;
         seen_ff       <= 1'b0;
         slots_ff      <= '0;
         lq_ptr_ff     <= '0;
         lq_total_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hvalid_ff     <= hvalid_in;
         bg_level_ff   <= bg_level_in;
         bg_valid_ff   <= bg_valid_in;
         near_peak_ff  <= near_peak_in;
         near_tally_ff <= near_tally_in;
         far_peak_ff   <= far_peak_in;
         far_tally_ff  <= far_tally_in;
         held_ff       <= held_in;
         last_ff       <= last_in;
         seen_ff       <= seen_in;
         slots_ff      <= slots_in;
         lq_ptr_ff     <= lq_ptr_in;
         lq_total_ff   <= lq_total_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      walk_ff     <= walk_in;
      total_ff    <= total_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      found_ff    <= found_in;
      out_ff      <= out_in;
   end

endmodule

// ===== rtl/rssi_background_notch_reporter_top.sv =====
// RSSI background notch reporter.
// req_ channel: one transaction per event (kind 0 packet, 1 empty dwell,
// 2 background update, 3 report), accepted when req_valid is high and
// req_stall is low. Only a report produces a rsp_ transaction.
// csr_ channel: register writes, index 0..4, taken when csr_valid and
// csr_ready are high; csr_ready is always high. Write only while idle.
// A four-entry queue separates the front end from the execution engine.
// Packet: engine states ST_PKT_RD then ST_PKT_WR (histogram RAM read, modify, write).
// Empty dwell: handled in ST_IDLE alone. Report: taken from the queue into the output
// register, which drives the rsp_ transaction.
// Background update: walks every bin, one per ST_BG_RD/ST_BG_WALK
// read/accumulate pair through the histogram RAM read port, then ST_CLEAR.
// Reset (synchronous, active high) empties the queue, clears histogram
// valid bits, statistics and registers to their reset values.
// When rsp_stall holds, the result stays in the output register; a later
// report waits in the engine and blocks the events behind it, so the
// queue fills and req_stall rises.
module rssi_background_notch_reporter_top #(
   parameter int HIST_BINS = rbnr_pkg::HIST_BINS_DEF,
   parameter int LQ_SLOTS  = rbnr_pkg::LQ_SLOTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rbnr_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rbnr_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rbnr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rbnr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   rbnr_pkg::cfg_type  cfg_ff, cfg_in;
   logic               cmd_valid;
   logic               cmd_pop;
   rbnr_pkg::cmd_type  cmd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rbnr_pkg::CSR_GUARD:    cfg_in.guard_db         = csr_wdata[6:0];
            rbnr_pkg::CSR_MIN_BG:   cfg_in.min_bg_packets   = csr_wdata;
            rbnr_pkg::CSR_MIN_NEAR: cfg_in.min_near_packets = csr_wdata[7:0];
            rbnr_pkg::CSR_HOLD:     cfg_in.hold_time_ms     = csr_wdata;
            rbnr_pkg::CSR_FLOOR:    cfg_in.floor_dbm        = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.guard_db         <= 7'd6;
         cfg_ff.min_bg_packets   <= 16'd20;
         cfg_ff.min_near_packets <= 8'd3;
         cfg_ff.hold_time_ms     <= 16'd500;
         cfg_ff.floor_dbm        <= -8'sd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbnr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   rbnr_back #(
      .HIST_BINS (HIST_BINS),
      .LQ_SLOTS  (LQ_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/rbnr_checker.sv =====
module rbnr_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rbnr_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_lq_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.lq_percent <= 7'd100)
      else $error("lq percent above 100");

   a_bg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.background_valid |-> rsp_data.background_dbm <= 8'sd0)
      else $error("background level positive");

   a_rst_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("outputs active after reset");

endmodule

bind rssi_background_notch_reporter_top rbnr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/rssi_background_notch_reporter_top_test.sv =====
`timescale 1ns / 1ps

module rssi_background_notch_reporter_top_test;

   localparam int NBINS  = 128;
   localparam int NSLOTS = 50;
   localparam int SETTLE = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rbnr_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rbnr_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [rbnr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rbnr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rssi_background_notch_reporter_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow of the block: registers and statistics
   rbnr_pkg::cfg_type  cfg;
   logic [15:0]        hist [NBINS];
   logic signed [7:0]  bg_lvl, near_pk, far_pk, held_pk;
   bit                 bg_ok, near_seen;
   logic [7:0]         near_n, far_n;
   logic [31:0]        near_time;
   bit [NSLOTS-1:0]    lq_bits;
   int                 lq_ptr, lq_cnt;

   rbnr_pkg::rsp_type reports_pending [$];
   int      mismatches = 0;
   bit      hold_request = 0;
   bit      hold_done = 0;
   int      hold_left = 0;
   int      stall_left = 0;

   task automatic shadow_reset();
      cfg = '{guard_db: 7'd6, min_bg_packets: 16'd20, min_near_packets: 8'd3,
              hold_time_ms: 16'd500, floor_dbm: -8'sd128};
      foreach (hist[k]) hist[k] = '0;
      bg_lvl = -8'sd128; near_pk = -8'sd128; far_pk = -8'sd128; held_pk = -8'sd128;
      bg_ok = 0; near_seen = 0; near_n = 0; far_n = 0; near_time = 0;
      lq_bits = '0; lq_ptr = 0; lq_cnt = 0;
   endtask

   task automatic lq_slot(input bit got);
      int p;
      p = (lq_ptr < NSLOTS) ? lq_ptr : 0;
      if (lq_bits[p] && lq_cnt > 0) lq_cnt--;
      lq_bits[p] = got;
      if (got) lq_cnt++;
      lq_ptr = (p + 1) % NSLOTS;
   endtask

   // advance the shadow by one event; report events yield a result
   task automatic predict_event(input rbnr_pkg::req_type r, output bit has_rsp,
                                output rbnr_pkg::rsp_type o);
      int v, idx, total, best, best_idx;
      logic signed [7:0] rep;
      v = r.rssi_dbm;
      has_rsp = 0;
      o = '0;
      case (rbnr_pkg::kind_type'(r.kind))
         rbnr_pkg::KIND_PACKET: begin
            idx = -v;
            if (idx < 0) idx = 0;
            if (idx > NBINS - 1) idx = NBINS - 1;
            if (hist[idx] != 16'hFFFF) hist[idx] = hist[idx] + 1;
            lq_slot(1);
            if (bg_ok) begin
               if (v > int'(bg_lvl) + int'(cfg.guard_db)) begin
                  if (v > near_pk) near_pk = r.rssi_dbm;
                  if (near_n != 8'hFF) near_n++;
               end else if (v < int'(bg_lvl) - int'(cfg.guard_db)) begin
                  if (v > far_pk) far_pk = r.rssi_dbm;
                  if (far_n != 8'hFF) far_n++;
               end
            end
         end
         rbnr_pkg::KIND_EMPTY: lq_slot(0);
         rbnr_pkg::KIND_BG: begin
            total = 0; best = 0; best_idx = -1;
            for (int k = 0; k < NBINS; k++) begin
               total += hist[k];
               if (hist[k] > best) begin
                  best = hist[k];
                  best_idx = k;
               end
            end
            if (total > 65535) total = 65535;
            bg_ok = (total >= cfg.min_bg_packets) && (best_idx >= 0);
            if (bg_ok) bg_lvl = 8'(-best_idx);
            foreach (hist[k]) hist[k] = '0;
         end
         default: begin
            if (bg_ok && near_n >= cfg.min_near_packets) begin
               held_pk = near_pk;
               near_time = r.now_ms;
               near_seen = 1;
               rep = near_pk;
            end else if (near_seen && (r.now_ms - near_time) < {16'd0, cfg.hold_time_ms}) begin
               rep = held_pk;
            end else begin
               rep = cfg.floor_dbm;
               held_pk = cfg.floor_dbm;
            end
            o.report_rssi      = rep;
            o.lq_percent       = 7'(lq_cnt * 100 / NSLOTS);
            o.near_count       = near_n;
            o.far_count        = far_n;
            o.far_max          = far_pk;
            o.background_dbm   = bg_lvl;
            o.background_valid = bg_ok;
            near_pk = cfg.floor_dbm; near_n = 0;
            far_pk = cfg.floor_dbm; far_n = 0;
            has_rsp = 1;
         end
      endcase
   endtask

   // offer one transaction after a random gap; update the shadow on acceptance
   task automatic offer_event(input rbnr_pkg::req_type d, input bit typed,
                              input rbnr_pkg::rsp_type typed_rsp, input bit no_gaps);
      int gap;
      bit has;
      rbnr_pkg::rsp_type p;
      gap = 0;
      if (!no_gaps && $urandom_range(0, 9) >= 7)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      predict_event(d, has, p);
      if (has) reports_pending.push_back(typed ? typed_rsp : p);
   endtask

   task automatic csr_write(input logic [rbnr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rbnr_pkg::CSR_GUARD:    cfg.guard_db = data[6:0];
         rbnr_pkg::CSR_MIN_BG:   cfg.min_bg_packets = data;
         rbnr_pkg::CSR_MIN_NEAR: cfg.min_near_packets = data[7:0];
         rbnr_pkg::CSR_HOLD:     cfg.hold_time_ms = data;
         rbnr_pkg::CSR_FLOOR:    cfg.floor_dbm = data[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (reports_pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 700;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 9) >= 7) begin
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100)
                                                    : $urandom_range(0, 3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rbnr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = reports_pending.pop_front();
            if (rsp_data.report_rssi !== want.report_rssi ||
                rsp_data.lq_percent !== want.lq_percent ||
                rsp_data.near_count !== want.near_count ||
                rsp_data.far_count !== want.far_count ||
                rsp_data.far_max !== want.far_max ||
                rsp_data.background_dbm !== want.background_dbm ||
                rsp_data.background_valid !== want.background_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   typedef struct {
      rbnr_pkg::req_type d;
      bit                typed;
      rbnr_pkg::rsp_type r;
   } directed_row;

   initial begin
      directed_row rows [$];
      directed_row row;
      rbnr_pkg::req_type e;
      rbnr_pkg::rsp_type none;
      logic [31:0] now_t;
      int          level, w, report_w, n;
      bit          burst;

      none = '0;
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every kind, empty histogram, held time near wrap
      row.typed = 1;
      row.d = '{kind: rbnr_pkg::KIND_REPORT, rssi_dbm: 8'sd0, now_ms: 32'd0};
      row.r = '{-8'sd128, 7'd0, 8'd0, 8'd0, -8'sd128, -8'sd128, 1'b0};
      rows.push_back(row);
      row.typed = 0;
      row.r = none;
      row.d = '{rbnr_pkg::KIND_PACKET, 8'sd127, 32'hFFFF_FFFF};  rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_PACKET, -8'sd128, 32'd0};         rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_PACKET, 8'sd0, 32'h5555_5555};    rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_PACKET, -8'sd1, 32'hAAAA_AAAA};   rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_EMPTY, 8'sd0, 32'd0};             rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_BG, 8'sd0, 32'd0};                rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_BG, 8'sd0, 32'd0};                rows.push_back(row);
      row.typed = 1;
      row.d = '{rbnr_pkg::KIND_REPORT, 8'sd0, 32'hFFFF_FFFF};
      row.r = '{-8'sd128, 7'd8, 8'd0, 8'd0, -8'sd128, -8'sd128, 1'b0};
      rows.push_back(row);
      row.typed = 0;
      for (int k = 0; k < 12; k++) begin
         row.d = '{rbnr_pkg::KIND_PACKET, -8'sd60, 32'd0};
         rows.push_back(row);
      end
      row.d = '{rbnr_pkg::KIND_BG, 8'sd0, 32'd0};                rows.push_back(row);
      row.d = '{rbnr_pkg::KIND_REPORT, 8'sd0, 32'd0};            rows.push_back(row);
      foreach (rows[k]) offer_event(rows[k].d, rows[k].typed, rows[k].r, 0);

      now_t = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            drain_and_settle();
            case (phase)
               1: begin
                  csr_write(rbnr_pkg::CSR_GUARD, 16'h0000);
                  csr_write(rbnr_pkg::CSR_MIN_BG, 16'h0000);
                  csr_write(rbnr_pkg::CSR_MIN_NEAR, 16'h0000);
                  csr_write(rbnr_pkg::CSR_HOLD, 16'h0000);
                  csr_write(rbnr_pkg::CSR_FLOOR, 16'hFF00);
               end
               2: begin
                  csr_write(rbnr_pkg::CSR_GUARD, 16'hFFFF);
                  csr_write(rbnr_pkg::CSR_MIN_BG, 16'hFFFF);
                  csr_write(rbnr_pkg::CSR_MIN_NEAR, 16'h00FF);
                  csr_write(rbnr_pkg::CSR_HOLD, 16'hFFFF);
                  csr_write(rbnr_pkg::CSR_FLOOR, 16'h0080);
               end
               3: begin
                  csr_write(rbnr_pkg::CSR_GUARD, 16'd3);
                  csr_write(rbnr_pkg::CSR_MIN_BG, 16'd10);
                  csr_write(rbnr_pkg::CSR_MIN_NEAR, 16'd1);
                  csr_write(rbnr_pkg::CSR_HOLD, 16'd1000);
                  csr_write(rbnr_pkg::CSR_FLOOR, {8'h5A, 8'(-90)});
               end
               4: begin
                  csr_write(rbnr_pkg::CSR_GUARD, 16'($urandom));
                  csr_write(rbnr_pkg::CSR_MIN_BG, 16'($urandom_range(0, 40)));
                  csr_write(rbnr_pkg::CSR_MIN_NEAR, 16'($urandom));
                  csr_write(rbnr_pkg::CSR_HOLD, 16'($urandom));
                  csr_write(rbnr_pkg::CSR_FLOOR, {8'($urandom), 8'(-$urandom_range(0, 128))});
                  csr_write(3'd5, 16'($urandom));
                  csr_write(3'd6, 16'($urandom));
                  csr_write(3'd7, 16'($urandom));
               end
               default: begin
                  csr_write(rbnr_pkg::CSR_GUARD, 16'd6);
                  csr_write(rbnr_pkg::CSR_MIN_BG, 16'd20);
                  csr_write(rbnr_pkg::CSR_MIN_NEAR, 16'd3);
                  csr_write(rbnr_pkg::CSR_HOLD, 16'd500);
                  csr_write(rbnr_pkg::CSR_FLOOR, 16'h0080);
               end
            endcase
         end
         report_w = (phase == 3) ? 20 : 140;
         level = -$urandom_range(10, 100);
         n = (phase == 0) ? 250 : 290;
         burst = 0;
         for (int k = 0; k < n; k++) begin
            if (phase == 5 && k == 40) hold_request = 1;
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            w = $urandom_range(0, 999);
            if ($urandom_range(0, 19) == 0) now_t = $urandom;
            else if ($urandom_range(0, 29) == 0) now_t = 0;
            else now_t += $urandom_range(0, 400);
            e.now_ms = now_t;
            e.rssi_dbm = 8'($urandom);
            if (w < report_w) e.kind = rbnr_pkg::KIND_REPORT;
            else if (w < report_w + 30) e.kind = rbnr_pkg::KIND_BG;
            else if (w < report_w + 90) e.kind = rbnr_pkg::KIND_EMPTY;
            else begin
               e.kind = rbnr_pkg::KIND_PACKET;
               if ($urandom_range(0, 9) < 7)
                  e.rssi_dbm = 8'(level + $urandom_range(0, 40) - 20);
            end
            if (e.kind == rbnr_pkg::KIND_BG && $urandom_range(0, 2) == 0)
               level = -$urandom_range(10, 100);
            offer_event(e, 0, none, burst);
         end
      end

      drain_and_settle();
      if (mismatches == 0 && reports_pending.size() == 0) begin
         $display("PASS rssi_background_notch_reporter_top");
      end else begin
         $display("FAIL rssi_background_notch_reporter_top");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("FAIL rssi_background_notch_reporter_top");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rbnr_pkg.sv
rtl/rbnr_front.sv
rtl/rbnr_back.sv
rtl/rssi_background_notch_reporter_top.sv
rtl/rbnr_checker.sv
sim/rssi_background_notch_reporter_top_test.sv
